// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, muted while reset is asserted
`define TPMQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpmq check failed");

// implication form of the same check
`define TPMQ_ASSERT_IMP(label, cond, prop) \
  `TPMQ_ASSERT(label, (cond) |=> (prop))

`endif

// ===== hw/rtl/tpmq_pkg.sv =====
package tpmq_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LEVELS      = 10;
  localparam int WEIGHT_W    = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_W       = NODE_W + 1;
  localparam int CNT_W       = 11;
  localparam int DEPTH_W     = 10;
  localparam int TOTAL_W     = 26;
  localparam int NEW_TOTAL_W = 27;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CMP_W       = DEPTH_W + LEVELS + 1;
  localparam int LIFT_AW     = NODE_W + LVL_W;
  localparam int LIFT_DEPTH  = 2 ** LIFT_AW;

  localparam logic [ANC_W-1:0] NO_NODE = '1;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_TOTAL = 1'b1;

  typedef struct packed {
    logic [ANC_W-1:0]    anc;
    logic [WEIGHT_W-1:0] w;
  } lift_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic [WEIGHT_W-1:0] pw;
  } node_t;

  function automatic logic in_use(input logic [ANC_W-1:0] x,
                                  input logic [CNT_W-1:0] cnt);
    logic lt_cnt;
    logic lt_max;
    lt_cnt = ({{(CNT_W+ANC_W){1'b0}}, x} < {{(2*ANC_W){1'b0}}, cnt});
    lt_max = (32'(x) < 32'(MAX_NODES));
    return lt_cnt && lt_max;
  endfunction

  function automatic logic [WEIGHT_W-1:0] wmax(input logic [WEIGHT_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/tree_path_max_query.sv =====
// load, cmd 3: block stays idle; build: levels 1..LEVELS-1, two reads and a write per node
// query: read both ends, climb the deeper end (absent endpoint: straight to the result),
//   then unless the ends met a joint climb and the parent weights, then the result
// one transaction at a time; a finished result waits in the output register
// reset clears control and the registers (node_count 1024, tree_total 0); table
// contents are undefined until loaded or built
module tree_path_max_query
  import tpmq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [NODE_W-1:0]      node_a_i,
  input  logic [NODE_W-1:0]      node_b_i,
  input  logic                   has_parent_i,
  input  logic [DEPTH_W-1:0]     node_level_i,
  input  logic [WEIGHT_W-1:0]    weight_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [WEIGHT_W-1:0]    path_max_o,
  output logic                   on_tree_o,
  output logic [NEW_TOTAL_W-1:0] new_total_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [TOTAL_W-1:0]     cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_B1   = 4'd1;
  localparam logic [3:0] S_B2   = 4'd2;
  localparam logic [3:0] S_B3   = 4'd3;
  localparam logic [3:0] S_Q1   = 4'd4;
  localparam logic [3:0] S_P1C  = 4'd5;
  localparam logic [3:0] S_P1L  = 4'd6;
  localparam logic [3:0] S_P1D  = 4'd7;
  localparam logic [3:0] S_P1E  = 4'd8;
  localparam logic [3:0] S_P2R  = 4'd9;
  localparam logic [3:0] S_P2U  = 4'd10;
  localparam logic [3:0] S_FR   = 4'd11;
  localparam logic [3:0] S_FU   = 4'd12;
  localparam logic [3:0] S_RES  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

  // memories
  lift_t lift_mem [LIFT_DEPTH];
  node_t node_mem [MAX_NODES];

  logic                lw_en, lr0_en, lr1_en;
  logic [LIFT_AW-1:0]  lw_addr, lr0_addr, lr1_addr;
  lift_t               lw_data, lr0_q, lr1_q;
  logic                nw_en, nr0_en, nr1_en;
  logic [NODE_W-1:0]   nw_addr, nr0_addr, nr1_addr;
  node_t               nw_data, nr0_q, nr1_q;

  always_ff @(posedge clk_i) begin
    if (lw_en) lift_mem[lw_addr] <= lw_data;
    if (lr0_en) lr0_q <= lift_mem[lr0_addr];
    if (lr1_en) lr1_q <= lift_mem[lr1_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) node_mem[nw_addr] <= nw_data;
    if (nr0_en) nr0_q <= node_mem[nr0_addr];
    if (nr1_en) nr1_q <= node_mem[nr1_addr];
  end

  // control and datapath registers
  logic [3:0]             state_q, state_d;
  logic [CNT_W-1:0]       node_count_q;
  logic [TOTAL_W-1:0]     tree_total_q;
  logic [LVL_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [ANC_W-1:0]       u_q, u_d, v_q, v_d;
  logic [DEPTH_W-1:0]     lu_q, lu_d, lv_q, lv_d;
  logic [WEIGHT_W-1:0]    best_q, best_d, w_q, w_d;
  logic [NODE_W-1:0]      a_q, a_d, b_q, b_d;
  logic                   tree_q, tree_d;
  logic                   out_valid_q, out_valid_d;
  logic [WEIGHT_W-1:0]    out_pm_q, out_pm_d;
  logic                   out_tree_q, out_tree_d;
  logic [NEW_TOTAL_W-1:0] out_total_q, out_total_d, res_total_q, res_total_d;

  logic                   accept;
  logic [CNT_W-1:0]       limit;
  logic [ANC_W-1:0]       ext_a, ext_b, mid, au, av;
  logic                   mid_in, climb;
  logic [CMP_W-1:0]       lu_ext, need;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign ext_a = {1'b0, node_a_i};
  assign ext_b = {1'b0, node_b_i};
  assign limit = (32'(node_count_q) < 32'(MAX_NODES)) ? node_count_q : CNT_W'(MAX_NODES);
  assign mid = lr0_q.anc;
  assign mid_in = in_use(mid, node_count_q);
  assign lu_ext = CMP_W'(lu_q);
  assign need = CMP_W'(lv_q) + (CMP_W'(1) << i_q);
  assign climb = in_use(u_q, node_count_q) && (lu_ext >= need);
  assign au = (in_use(u_q, node_count_q) && in_use(lr0_q.anc, node_count_q)) ?
              lr0_q.anc : NO_NODE;
  assign av = (in_use(v_q, node_count_q) && in_use(lr1_q.anc, node_count_q)) ?
              lr1_q.anc : NO_NODE;

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    n_d = n_q;
    u_d = u_q;
    v_d = v_q;
    lu_d = lu_q;
    lv_d = lv_q;
    best_d = best_q;
    w_d = w_q;
    a_d = a_q;
    b_d = b_q;
    tree_d = tree_q;
    res_total_d = res_total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pm_d = out_pm_q;
    out_tree_d = out_tree_q;
    out_total_d = out_total_q;
    lw_en = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    lr0_en = 1'b0;
    lr0_addr = '0;
    lr1_en = 1'b0;
    lr1_addr = '0;
    nw_en = 1'b0;
    nw_addr = '0;
    nw_data = '0;
    nr0_en = 1'b0;
    nr0_addr = '0;
    nr1_en = 1'b0;
    nr1_addr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i))
            CMD_LOAD: begin
              if (in_use(ext_a, node_count_q)) begin
                lw_en = 1'b1;
                lw_addr = {node_a_i, LVL_W'(0)};
                lw_data.anc = (has_parent_i && in_use(ext_b, node_count_q)) ? ext_b : NO_NODE;
                lw_data.w = weight_i;
                nw_en = 1'b1;
                nw_addr = node_a_i;
                nw_data.depth = node_level_i;
                nw_data.pw = weight_i;
              end
            end
            CMD_BUILD: begin
              if (LEVELS > 1) begin
                i_d = LVL_W'(1);
                n_d = '0;
                state_d = S_B1;
              end
            end
            CMD_QUERY: begin
              w_d = weight_i;
              a_d = node_a_i;
              b_d = node_b_i;
              if (in_use(ext_a, node_count_q) && in_use(ext_b, node_count_q)) begin
                nr0_en = 1'b1;
                nr0_addr = node_a_i;
                nr1_en = 1'b1;
                nr1_addr = node_b_i;
                lr0_en = 1'b1;
                lr0_addr = {node_a_i, LVL_W'(0)};
                lr1_en = 1'b1;
                lr1_addr = {node_b_i, LVL_W'(0)};
                state_d = S_Q1;
              end else begin
                // absent endpoint: total passes through unchanged
                best_d = '0;
                w_d = '0;
                tree_d = 1'b0;
                state_d = S_RES;
              end
            end
            default: ;
          endcase
        end
      end
      S_B1: begin
        if (n_q < limit) begin
          lr0_en = 1'b1;
          lr0_addr = {n_q[NODE_W-1:0], LVL_W'(i_q - 1'b1)};
          state_d = S_B2;
        end else if (i_q == LVL_TOP) begin
          state_d = S_IDLE;
        end else begin
          i_d = i_q + 1'b1;
          n_d = '0;
        end
      end
      S_B2: begin
        lr1_en = 1'b1;
        lr1_addr = {mid[NODE_W-1:0], LVL_W'(i_q - 1'b1)};
        state_d = S_B3;
      end
      S_B3: begin
        lw_en = 1'b1;
        lw_addr = {n_q[NODE_W-1:0], i_q};
        lw_data.anc = (mid_in && in_use(lr1_q.anc, node_count_q)) ? lr1_q.anc : NO_NODE;
        lw_data.w = wmax(lr0_q.w, mid_in ? lr1_q.w : '0);
        n_d = n_q + 1'b1;
        state_d = S_B1;
      end
      S_Q1: begin
        tree_d = (a_q != b_q) &&
                 ((lr0_q.anc == {1'b0, b_q}) || (lr1_q.anc == {1'b0, a_q}));
        best_d = '0;
        i_d = LVL_TOP;
        // u is the deeper endpoint
        if (nr0_q.depth < nr1_q.depth) begin
          u_d = {1'b0, b_q};
          lu_d = nr1_q.depth;
          v_d = {1'b0, a_q};
          lv_d = nr0_q.depth;
        end else begin
          u_d = {1'b0, a_q};
          lu_d = nr0_q.depth;
          v_d = {1'b0, b_q};
          lv_d = nr1_q.depth;
        end
        state_d = S_P1C;
      end
      S_P1C: begin
        if (climb) begin
          lr0_en = 1'b1;
          lr0_addr = {u_q[NODE_W-1:0], i_q};
          state_d = S_P1L;
        end else if (i_q == '0) begin
          state_d = S_P1E;
        end else begin
          i_d = i_q - 1'b1;
        end
      end
      S_P1L: begin
        best_d = wmax(best_q, lr0_q.w);
        u_d = in_use(lr0_q.anc, node_count_q) ? lr0_q.anc : NO_NODE;
        nr0_en = 1'b1;
        nr0_addr = lr0_q.anc[NODE_W-1:0];
        state_d = S_P1D;
      end
      S_P1D: begin
        lu_d = in_use(u_q, node_count_q) ? nr0_q.depth : '0;
        if (i_q == '0) begin
          state_d = S_P1E;
        end else begin
          i_d = i_q - 1'b1;
          state_d = S_P1C;
        end
      end
      S_P1E: begin
        if (u_q == v_q) begin
          state_d = S_RES;
        end else begin
          i_d = LVL_TOP;
          state_d = S_P2R;
        end
      end
      S_P2R: begin
        lr0_en = 1'b1;
        lr0_addr = {u_q[NODE_W-1:0], i_q};
        lr1_en = 1'b1;
        lr1_addr = {v_q[NODE_W-1:0], i_q};
        state_d = S_P2U;
      end
      S_P2U: begin
        if ((au != NO_NODE) && (au != av)) begin
          best_d = wmax(best_q, wmax(lr0_q.w, in_use(v_q, node_count_q) ? lr1_q.w : '0));
          u_d = au;
          v_d = av;
        end
        if (i_q == '0) begin
          state_d = S_FR;
        end else begin
          i_d = i_q - 1'b1;
          state_d = S_P2R;
        end
      end
      S_FR: begin
        nr0_en = 1'b1;
        nr0_addr = u_q[NODE_W-1:0];
        nr1_en = 1'b1;
        nr1_addr = v_q[NODE_W-1:0];
        state_d = S_FU;
      end
      S_FU: begin
        best_d = wmax(best_q, wmax(in_use(u_q, node_count_q) ? nr0_q.pw : '0,
                                   in_use(v_q, node_count_q) ? nr1_q.pw : '0));
        state_d = S_RES;
      end
      S_RES: begin
        if (tree_q) begin
          res_total_d = NEW_TOTAL_W'(tree_total_q);
        end else begin
          res_total_d = NEW_TOTAL_W'(tree_total_q) - NEW_TOTAL_W'(best_q)
                      + NEW_TOTAL_W'(w_q);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pm_d = best_q;
          out_tree_d = tree_q;
          out_total_d = res_total_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      node_count_q <= NODE_COUNT_RST;
      tree_total_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NODE_COUNT: node_count_q <= cfg_data_i[CNT_W-1:0];
          REG_TREE_TOTAL: tree_total_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    n_q <= n_d;
    u_q <= u_d;
    v_q <= v_d;
    lu_q <= lu_d;
    lv_q <= lv_d;
    best_q <= best_d;
    w_q <= w_d;
    a_q <= a_d;
    b_q <= b_d;
    tree_q <= tree_d;
    res_total_q <= res_total_d;
    out_pm_q <= out_pm_d;
    out_tree_q <= out_tree_d;
    out_total_q <= out_total_d;
  end

  assign out_valid_o = out_valid_q;
  assign path_max_o = out_pm_q;
  assign on_tree_o = out_tree_q;
  assign new_total_o = out_total_q;

endmodule

// ===== hw/rtl/tpmq_checker.sv =====
`include "assert_macros.svh"

module tpmq_checker
  import tpmq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [CMD_W-1:0]       cmd_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [WEIGHT_W-1:0]    path_max_o,
  input logic                   on_tree_o,
  input logic [NEW_TOTAL_W-1:0] new_total_o
);

  logic in_txn;
  logic out_stall;

  assign in_txn = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // a query leaves the block busy in the cycle after it is accepted
  `TPMQ_ASSERT_IMP(a_query_busy, in_txn && (cmd_i == CMD_QUERY), !in_ready_o)
  // load, build and unused codes never produce a result
  `TPMQ_ASSERT_IMP(a_no_spurious, in_txn && (cmd_i != CMD_QUERY) && !out_valid_o,
                   !out_valid_o)
  // a waiting result holds
  `TPMQ_ASSERT_IMP(a_out_hold, out_stall,
                   out_valid_o && $stable(path_max_o) && $stable(on_tree_o)
                   && $stable(new_total_o))

endmodule

bind tree_path_max_query tpmq_checker u_tpmq_checker (.*);

// ===== sim/tb_tree_path_max_query.sv =====
`timescale 1ns / 100ps

module tb_tree_path_max_query;
  import tpmq_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct {
    cmd_e                cmd;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic                hp;
    logic [DEPTH_W-1:0]  lvl;
    logic [WEIGHT_W-1:0] w;
  } tree_op_t;

  typedef struct {
    logic [WEIGHT_W-1:0]    pm;
    logic                   on;
    logic [NEW_TOTAL_W-1:0] tot;
  } path_answer_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [CMD_W-1:0]       cmd_i = '0;
  logic [NODE_W-1:0]      node_a_i = '0;
  logic [NODE_W-1:0]      node_b_i = '0;
  logic                   has_parent_i = 1'b0;
  logic [DEPTH_W-1:0]     node_level_i = '0;
  logic [WEIGHT_W-1:0]    weight_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [WEIGHT_W-1:0]    path_max_o;
  logic                   on_tree_o;
  logic [NEW_TOTAL_W-1:0] new_total_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [TOTAL_W-1:0]     cfg_data_i = '0;

  tree_path_max_query i_dut (.*);

  // shadow copy of the tree and its lifting tables, -1 means no ancestor
  int               shadow_count;
  logic [TOTAL_W-1:0] shadow_total;
  int               lift_anc [MAX_NODES][LEVELS];
  int               lift_max [MAX_NODES][LEVELS];
  int               node_depth [MAX_NODES];
  int               node_pw [MAX_NODES];

  tree_op_t     pending_ops[$];
  path_answer_t path_answers[$];
  int           mismatches = 0;
  int           queries_seen = 0;
  int           cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_mode = 0;
  int           parent_of [MAX_NODES];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit live(int x);
    return x >= 0 && x < shadow_count && x < MAX_NODES;
  endfunction

  function automatic int lift(int x, int l);
    int a;
    if (!live(x)) return -1;
    a = lift_anc[x][l];
    return live(a) ? a : -1;
  endfunction

  function automatic int lift_w(int x, int l);
    return live(x) ? lift_max[x][l] : 0;
  endfunction

  function automatic int depth_of(int x);
    return live(x) ? node_depth[x] : 0;
  endfunction

  function automatic int pw_of(int x);
    return live(x) ? node_pw[x] : 0;
  endfunction

  function automatic int maxi(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic int path_maximum(int u_in, int v_in);
    int u, v, t, best, au, av;
    u = u_in;
    v = v_in;
    best = 0;
    if (depth_of(u) < depth_of(v)) begin
      t = u; u = v; v = t;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (live(u) && depth_of(u) >= depth_of(v) + (1 << i)) begin
        best = maxi(best, lift_w(u, i));
        u = lift(u, i);
      end
    end
    if (u == v) return best;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      au = lift(u, i);
      av = lift(v, i);
      if (au != -1 && au != av) begin
        best = maxi(best, maxi(lift_w(u, i), lift_w(v, i)));
        u = au;
        v = av;
      end
    end
    return maxi(best, maxi(pw_of(u), pw_of(v)));
  endfunction

  task automatic apply_op(input tree_op_t op);
    path_answer_t ans;
    int mid;
    case (op.cmd)
      CMD_LOAD: begin
        if (live(op.a)) begin
          lift_anc[op.a][0] = (op.hp && live(op.b)) ? int'(op.b) : -1;
          lift_max[op.a][0] = op.w;
          node_pw[op.a] = op.w;
          node_depth[op.a] = op.lvl;
        end
      end
      CMD_BUILD: begin
        for (int j = 1; j < LEVELS; j++) begin
          for (int i = 0; i < shadow_count && i < MAX_NODES; i++) begin
            mid = lift(i, j - 1);
            lift_anc[i][j] = lift(mid, j - 1);
            lift_max[i][j] = maxi(lift_max[i][j-1], lift_w(mid, j - 1));
          end
        end
      end
      CMD_QUERY: begin
        ans.pm = '0;
        ans.on = 1'b0;
        ans.tot = NEW_TOTAL_W'(shadow_total);
        if (live(op.a) && live(op.b)) begin
          ans.on = (op.a != op.b) && (lift(op.a, 0) == op.b || lift(op.b, 0) == op.a);
          ans.pm = WEIGHT_W'(path_maximum(op.a, op.b));
          if (!ans.on) ans.tot = NEW_TOTAL_W'(shadow_total) - ans.pm + op.w;
        end
        path_answers = {path_answers, ans};
      end
      default: ;
    endcase
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    tree_op_t op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        op.cmd = cmd_e'(cmd_i);
        op.a = node_a_i;
        op.b = node_b_i;
        op.hp = has_parent_i;
        op.lvl = node_level_i;
        op.w = weight_i;
        apply_op(op);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          cmd_i <= op.cmd;
          node_a_i <= op.a;
          node_b_i <= op.b;
          has_parent_i <= op.hp;
          node_level_i <= op.lvl;
          weight_i <= op.w;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor with its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    path_answer_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (cycles % 600 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
      if (out_valid_o && out_ready_i) begin
        queries_seen++;
        if (path_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
        end else begin
          want = path_answers.pop_front();
          if (path_max_o !== want.pm || on_tree_o !== want.on || new_total_o !== want.tot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: path_max %0d/%0d on_tree %0d/%0d new_total %0d/%0d",
                       want.pm, path_max_o, want.on, on_tree_o, want.tot, new_total_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_op(cmd_e c, int a, int b, bit hp, int lvl, int w);
    tree_op_t op;
    op.cmd = c;
    op.a = NODE_W'(a);
    op.b = NODE_W'(b);
    op.hp = hp;
    op.lvl = DEPTH_W'(lvl);
    op.w = WEIGHT_W'(w);
    pending_ops = {pending_ops, op};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NODE_COUNT) shadow_count = val[CNT_W-1:0];
    else shadow_total = val;
  endtask

  task automatic drain(int n);
    while (pending_ops.size() > 0 || in_valid_i || path_answers.size() > 0) @(posedge clk_i);
    // a build produces no result, so give it time to finish
    repeat (27 * n + 60) @(posedge clk_i);
  endtask

  function automatic int rand_weight();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // loads are queued in node order so each depth follows its parent
  int load_depth [MAX_NODES];
  task automatic node_depth_tmp_push(int i, int p);
    bit odd;
    int d;
    odd = ($urandom_range(0, 49) == 0);
    d = (p < 0) ? 0 : load_depth[p] + 1;
    if (odd) d = $urandom_range(0, 1023);
    load_depth[i] = d;
    push_op(CMD_LOAD, i, (p < 0) ? $urandom_range(0, 1023) : p, p >= 0, d, rand_weight());
  endtask

  task automatic run_tree(int n, logic [TOTAL_W-1:0] total, int nq, int chain_pct);
    int p;
    write_reg(REG_NODE_COUNT, TOTAL_W'(n));
    write_reg(REG_TREE_TOTAL, total);
    parent_of[0] = -1;
    for (int i = 1; i < n; i++) begin
      p = ($urandom_range(0, 99) < chain_pct) ? i - 1 : $urandom_range(0, i - 1);
      // now and then a parent outside the tree, which makes an extra root
      if (n < MAX_NODES && $urandom_range(0, 99) == 0) p = $urandom_range(n, MAX_NODES - 1);
      parent_of[i] = (p >= n) ? -1 : p;
      if (p >= n) begin
        load_depth[i] = 0;
      end
    end
    node_depth_tmp_push(0, -1);
    for (int i = 1; i < n; i++) begin
      if (parent_of[i] < 0) begin
        load_depth[i] = 0;
        push_op(CMD_LOAD, i, $urandom_range(n, MAX_NODES - 1), 1, 0, rand_weight());
      end else begin
        node_depth_tmp_push(i, parent_of[i]);
      end
    end
    run_queries(n, nq);
  endtask

  task automatic run_queries(int n, int nq);
    int a, b, r;
    for (int i = 0; i < 2; i++)
      if (n < MAX_NODES) push_op(CMD_LOAD, $urandom_range(n, MAX_NODES - 1),
                                 $urandom_range(0, 1023), 1, $urandom_range(0, 1023),
                                 rand_weight());
    push_op(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023), 1,
            $urandom_range(0, 1023), rand_weight());
    push_op(CMD_BUILD, 0, 0, 0, 0, 0);
    for (int q = 0; q < nq; q++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if (r < 15 && parent_of[a] >= 0) begin
        if ($urandom_range(0, 1)) b = parent_of[a];
        else begin
          b = a;
          a = parent_of[b];
        end
      end else if (r < 20) begin
        b = a;
      end else if (r < 28) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else if (r < 30) begin
        push_op(CMD_NONE, a, b, $urandom_range(0, 1), $urandom_range(0, 1023), rand_weight());
        continue;
      end
      push_op(CMD_QUERY, a, b, $urandom_range(0, 1), $urandom_range(0, 1023), rand_weight());
    end
    drain(n);
  endtask

  initial begin
    shadow_count = 1024;
    shadow_total = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed corners: single node, two nodes, full tree with the largest total
    run_tree(1, '0, 8, 0);
    run_tree(2, TOTAL_MAX, 12, 100);
    run_tree(MAX_NODES, TOTAL_MAX, 150, 75);
    for (int k = 0; k < 3; k++)
      run_tree($urandom_range(3, 60),
               (k % 3 == 0) ? '0 : TOTAL_W'($urandom_range(0, 67108863)),
               $urandom_range(30, 50), $urandom_range(0, 100));
    $display("ran %0d query results over trees of 1 to %0d nodes", queries_seen, MAX_NODES);
    $display("with both total extremes, absent ids, tree edges and idle commands");
    if (mismatches == 0 && path_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, path_answers.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tpmq_pkg.sv
hw/rtl/tree_path_max_query.sv
hw/rtl/tpmq_checker.sv
sim/tb_tree_path_max_query.sv
